// ----- rtl/bccc_pkg.sv -----
`timescale 1ns / 1ps

package bccc_pkg;

  // Moving-average window depth and the widths that follow from it
  localparam int SAMPLE_WINDOW = 16;
  localparam int IDX_W  = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
  localparam int FILL_W = $clog2(SAMPLE_WINDOW + 1);
  // |sample| <= 2000000 < 2^21, so |sum| < 2^(21 + log2 depth)
  localparam int MAG_W  = 21 + $clog2(SAMPLE_WINDOW);
  localparam int SUM_W  = MAG_W + 1;

  // Field and register widths
  localparam int ADC_W      = 12;
  localparam int CUR_W      = 22;
  localparam int SOC_W      = 14;
  localparam int TOT_W      = 33;
  localparam int OFS_W      = 11;
  localparam int GAIN_W     = 12;
  localparam int RATIO_W    = 11;
  localparam int FS_W       = 14;
  localparam int CAPAH_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 3'd5;

  // Arithmetic constants
  localparam int MV_MIDPOINT   = 2000;
  localparam int PERMILLE      = 1000;
  localparam int CURRENT_LIMIT = 2000000;
  localparam int CLASS_LIMIT   = 3000;
  localparam int MAS_PER_AH    = 3600000;
  localparam int SOC_FULL      = 10000;
  localparam logic [TOT_W-1:0] TOTAL_LIMIT = 33'd7200000000;

  // Shared serial multiply/divide unit
  localparam int AR_W  = 48;
  localparam int AR_BW = 32;
  localparam int AR_CW = 6;
  localparam logic AR_OP_MUL = 1'b0;
  localparam logic AR_OP_DIV = 1'b1;

  typedef struct packed {
    logic             start;
    logic             op;
    logic [AR_W-1:0]  a;
    logic [AR_BW-1:0] b;
    logic [AR_CW-1:0] cnt;
  } ar_req_t;

  typedef struct packed {
    logic            done;
    logic [AR_W-1:0] result;
  } ar_rsp_t;

endpackage

// ----- rtl/battery_current_coulomb_counter.sv -----
`timescale 1ns / 1ps

// Coulomb counter: turns each Hall CT sample (mV) into signed mA, keeps a
// moving average over the last 16 samples, and on words flagged with the
// one-second tick classes the average (charging above 3 A, discharging below
// -3 A), accumulates saturating mA-second totals and updates state of charge
// in 0.01 % steps. One word is processed at a time. Every multiply and divide
// runs on one shared bit-serial shift-and-add unit at one bit per clock. A
// word without the tick runs the gain multiply, the divide by 1000, the ratio
// multiply, the full-scale divide and the average divide, each handed off to
// the unit in turn, and then writes back. A tick adds the capacity multiply,
// which alone settles it with a pending full-charge request or SOC at full or
// empty; otherwise the SOC scale and SOC divide also run. A finished word
// sits in the output register while the next input word is taken; a stalled
// output holds the next word in its last step.
module battery_current_coulomb_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [bccc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bccc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bccc_pkg::ADC_W-1:0]           in_adc_millivolts,
  input  logic                                 in_second_elapsed,
  input  logic                                 in_full_charge_request,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bccc_pkg::CUR_W-1:0]    out_current_ma,
  output logic signed [bccc_pkg::CUR_W-1:0]    out_average_ma,
  output logic [bccc_pkg::SOC_W-1:0]           out_soc_hundredths,
  output logic                                 out_charging,
  output logic                                 out_discharging,
  output logic [bccc_pkg::TOT_W-1:0]           out_charged_mas,
  output logic [bccc_pkg::TOT_W-1:0]           out_discharged_mas
);
  import bccc_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GAIN  = 4'd1;
  localparam logic [3:0] ST_K1000 = 4'd2;
  localparam logic [3:0] ST_RATIO = 4'd3;
  localparam logic [3:0] ST_FS    = 4'd4;
  localparam logic [3:0] ST_AVG   = 4'd5;
  localparam logic [3:0] ST_CAP   = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_SOC   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // Serial step counts for each operation
  localparam int GAIN_BITS  = GAIN_W;      // m * gain, multiplier bits
  localparam int K_DIV_BITS = 25;          // m * gain < 2^25
  localparam int RATIO_BITS = 21;          // ratio * 1000 < 2^21
  localparam int FS_DIV_BITS = 37;         // 2|v| * ratio * 1000 < 2^37
  localparam int CAP_BITS   = CAPAH_W;     // capacity multiplier bits
  localparam int SCALE_BITS = 14;          // 10000 < 2^14
  localparam int SOC_DIV_BITS = 46;        // now * 10000 < 2^46

  // Configuration registers
  logic signed [OFS_W-1:0] offset_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [RATIO_W-1:0]      ratio_r;
  logic [FS_W-1:0]         fs_r;
  logic                    inv_r;
  logic [CAPAH_W-1:0]      cap_ah_r;

  // Sequencer and datapath state
  logic [3:0]              state_r, state_nxt;
  logic                    tick_r, tick_nxt;
  logic                    pend_r, pend_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [CUR_W-1:0] cur_r, cur_nxt;
  logic signed [CUR_W-1:0] avg_r, avg_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [IDX_W-1:0]        wi_r, wi_nxt;
  logic signed [CUR_W-1:0] store_r [SAMPLE_WINDOW];
  logic                    store_we;
  logic [TOT_W-1:0]        ct_r, ct_nxt;
  logic [TOT_W-1:0]        dt_r, dt_nxt;
  logic                    chg_r, chg_nxt;
  logic                    dis_r, dis_nxt;
  logic [SOC_W-1:0]        soc_r, soc_nxt;
  logic [AR_BW-1:0]        cap_r, cap_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [CUR_W-1:0] ocur_r, oavg_r;
  logic [SOC_W-1:0]        osoc_r;
  logic                    ochg_r, odis_r;
  logic [TOT_W-1:0]        oct_r, odt_r;
  logic                    out_load;

  ar_req_t req;
  ar_rsp_t rsp;

  // Combinational helpers
  logic signed [13:0]      m_sum;
  logic [12:0]             m_clip;
  logic [14:0]             mg;
  logic signed [15:0]      v_diff;
  logic                    v_neg;
  logic [15:0]             v_abs;
  logic [15:0]             v_mag;
  logic [20:0]             ratio_k;
  logic [FS_W-1:0]         fs_eff;
  logic [CAPAH_W-1:0]      cap_eff;
  logic [20:0]             cur_mag;
  logic [CUR_W-1:0]        cur_pos;
  logic signed [CUR_W-1:0] cur_val;
  logic signed [CUR_W-1:0] old_smp;
  logic                    win_full;
  logic signed [SUM_W-1:0] sum_new;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_negv;
  logic [MAG_W-1:0]        sum_mag;
  logic [FILL_W-1:0]       fill_new;
  logic [CUR_W-1:0]        avg_q;
  logic signed [CUR_W-1:0] avg_val;
  logic                    chg_now, dis_now;
  logic [TOT_W:0]          tot_sum;
  logic [TOT_W-1:0]        tot_sat;
  logic [AR_BW-1:0]        cap_new;
  logic signed [TOT_W:0]   d_val;
  logic                    d_le0, d_ge_cap;
  logic [AR_BW-1:0]        now_val;

  bccc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Sample conditioning
  assign m_sum   = $signed({2'b00, in_adc_millivolts}) + $signed({{3{offset_r[OFS_W-1]}}, offset_r});
  assign m_clip  = m_sum[13] ? 13'd0 : m_sum[12:0];
  assign mg      = rsp.result[14:0];
  assign v_diff  = $signed({1'b0, mg}) - 16'(MV_MIDPOINT);
  assign v_neg   = v_diff[15];
  assign v_abs   = v_neg ? 16'(-v_diff) : 16'(v_diff);
  assign v_mag   = {v_abs[14:0], 1'b0};
  // ratio * 1000 = ratio * (1024 - 16 - 8)
  assign ratio_k = {ratio_r, 10'b0} - {6'b0, ratio_r, 4'b0} - {7'b0, ratio_r, 3'b0};
  assign fs_eff  = (fs_r == '0) ? FS_W'(1) : fs_r;
  assign cap_eff = (cap_ah_r == '0) ? CAPAH_W'(1) : cap_ah_r;

  // Saturate current magnitude, then apply sign
  assign cur_mag = (rsp.result > AR_W'(CURRENT_LIMIT)) ? 21'(CURRENT_LIMIT)
                                                      : rsp.result[20:0];
  assign cur_pos = {1'b0, cur_mag};
  assign cur_val = (neg_r ^ inv_r) ? $signed(-cur_pos) : $signed(cur_pos);

  // Window bookkeeping
  assign old_smp  = store_r[wi_r];
  assign win_full = (fill_r == FILL_W'(SAMPLE_WINDOW));
  assign sum_new  = sum_r + SUM_W'(cur_val) - (win_full ? SUM_W'(old_smp) : SUM_W'(0));
  assign sum_neg  = sum_new[SUM_W-1];
  assign sum_negv = -sum_new;
  assign sum_mag  = sum_neg ? sum_negv[MAG_W-1:0] : sum_new[MAG_W-1:0];
  assign fill_new = win_full ? fill_r : fill_r + 1'b1;

  // Average and tick classification
  assign avg_q   = rsp.result[CUR_W-1:0];
  assign avg_val = neg_r ? $signed(-avg_q) : $signed(avg_q);
  assign chg_now = (avg_val > $signed(CUR_W'(CLASS_LIMIT)));
  assign dis_now = (avg_val < -$signed(CUR_W'(CLASS_LIMIT)));
  assign tot_sum = {1'b0, (chg_now ? ct_r : dt_r)} + (TOT_W+1)'(avg_q);
  assign tot_sat = (tot_sum > {1'b0, TOTAL_LIMIT}) ? TOTAL_LIMIT : tot_sum[TOT_W-1:0];

  // SOC: d = discharged - charged against capacity
  assign cap_new  = rsp.result[AR_BW-1:0];
  assign d_val    = $signed({1'b0, dt_r}) - $signed({1'b0, ct_r});
  assign d_le0    = d_val[TOT_W] || (d_val == '0);
  assign d_ge_cap = !d_val[TOT_W] && (d_val[TOT_W-1:0] >= TOT_W'(cap_new));
  assign now_val  = cap_new - d_val[AR_BW-1:0];

  assign out_load = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    pend_nxt      = pend_r;
    neg_nxt       = neg_r;
    cur_nxt       = cur_r;
    avg_nxt       = avg_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    wi_nxt        = wi_r;
    store_we      = 1'b0;
    ct_nxt        = ct_r;
    dt_nxt        = dt_r;
    chg_nxt       = chg_r;
    dis_nxt       = dis_r;
    soc_nxt       = soc_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r && out_stall;
    req           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tick_nxt  = in_second_elapsed;
          pend_nxt  = pend_r | in_full_charge_request;
          req.start = 1'b1;
          req.op    = AR_OP_MUL;
          req.a     = AR_W'(m_clip);
          req.b     = AR_BW'(gain_r);
          req.cnt   = AR_CW'(GAIN_BITS);
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = AR_OP_DIV;
          req.a     = AR_W'(rsp.result[K_DIV_BITS-1:0]) << (AR_W - K_DIV_BITS);
          req.b     = AR_BW'(PERMILLE);
          req.cnt   = AR_CW'(K_DIV_BITS);
          state_nxt = ST_K1000;
        end
      end
      ST_K1000: begin
        if (rsp.done) begin
          neg_nxt   = v_neg;
          req.start = 1'b1;
          req.op    = AR_OP_MUL;
          req.a     = AR_W'(v_mag);
          req.b     = AR_BW'(ratio_k);
          req.cnt   = AR_CW'(RATIO_BITS);
          state_nxt = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = AR_OP_DIV;
          req.a     = AR_W'(rsp.result[FS_DIV_BITS-1:0]) << (AR_W - FS_DIV_BITS);
          req.b     = AR_BW'(fs_eff);
          req.cnt   = AR_CW'(FS_DIV_BITS);
          state_nxt = ST_FS;
        end
      end
      ST_FS: begin
        if (rsp.done) begin
          cur_nxt   = cur_val;
          store_we  = 1'b1;
          sum_nxt   = sum_new;
          fill_nxt  = fill_new;
          wi_nxt    = (wi_r == IDX_W'(SAMPLE_WINDOW - 1)) ? '0 : wi_r + 1'b1;
          neg_nxt   = sum_neg;
          req.start = 1'b1;
          req.op    = AR_OP_DIV;
          req.a     = AR_W'(sum_mag) << (AR_W - MAG_W);
          req.b     = AR_BW'(fill_new);
          req.cnt   = AR_CW'(MAG_W);
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (rsp.done) begin
          avg_nxt = avg_val;
          if (tick_r) begin
            chg_nxt = chg_now;
            dis_nxt = dis_now;
            if (chg_now) begin
              ct_nxt = tot_sat;
            end else if (dis_now) begin
              dt_nxt = tot_sat;
            end
            req.start = 1'b1;
            req.op    = AR_OP_MUL;
            req.a     = AR_W'(MAS_PER_AH);
            req.b     = AR_BW'(cap_eff);
            req.cnt   = AR_CW'(CAP_BITS);
            state_nxt = ST_CAP;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_CAP: begin
        if (rsp.done) begin
          cap_nxt = cap_new;
          if (pend_r) begin
            // Full-charge request overrides the totals
            ct_nxt    = TOT_W'(cap_new);
            dt_nxt    = '0;
            pend_nxt  = 1'b0;
            soc_nxt   = SOC_W'(SOC_FULL);
            state_nxt = ST_OUT;
          end else if (d_le0) begin
            // At or above full: clamp and clear totals
            soc_nxt   = SOC_W'(SOC_FULL);
            ct_nxt    = '0;
            dt_nxt    = '0;
            state_nxt = ST_OUT;
          end else if (d_ge_cap) begin
            soc_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            req.start = 1'b1;
            req.op    = AR_OP_MUL;
            req.a     = AR_W'(now_val);
            req.b     = AR_BW'(SOC_FULL);
            req.cnt   = AR_CW'(SCALE_BITS);
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = AR_OP_DIV;
          req.a     = AR_W'(rsp.result[SOC_DIV_BITS-1:0]) << (AR_W - SOC_DIV_BITS);
          req.b     = cap_r;
          req.cnt   = AR_CW'(SOC_DIV_BITS);
          state_nxt = ST_SOC;
        end
      end
      ST_SOC: begin
        if (rsp.done) begin
          soc_nxt   = rsp.result[SOC_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      sum_r       <= '0;
      fill_r      <= '0;
      wi_r        <= '0;
      avg_r       <= '0;
      ct_r        <= '0;
      dt_r        <= '0;
      chg_r       <= 1'b0;
      dis_r       <= 1'b0;
      soc_r       <= SOC_W'(SOC_FULL);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      wi_r        <= wi_nxt;
      avg_r       <= avg_nxt;
      ct_r        <= ct_nxt;
      dt_r        <= dt_nxt;
      chg_r       <= chg_nxt;
      dis_r       <= dis_nxt;
      soc_r       <= soc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and sample window
  always_ff @(posedge clk) begin
    tick_r <= tick_nxt;
    neg_r  <= neg_nxt;
    cur_r  <= cur_nxt;
    cap_r  <= cap_nxt;
    if (store_we) begin
      store_r[wi_r] <= cur_val;
    end
    if (state_r == ST_OUT && out_load) begin
      ocur_r <= cur_r;
      oavg_r <= avg_r;
      osoc_r <= soc_r;
      ochg_r <= chg_r;
      odis_r <= dis_r;
      oct_r  <= ct_r;
      odt_r  <= dt_r;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      gain_r   <= GAIN_W'(PERMILLE);
      ratio_r  <= RATIO_W'(100);
      fs_r     <= FS_W'(4000);
      inv_r    <= 1'b0;
      cap_ah_r <= CAPAH_W'(100);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OFFSET: offset_r <= $signed(cfg_wdata[OFS_W-1:0]);
        CFG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_RATIO:  ratio_r  <= cfg_wdata[RATIO_W-1:0];
        CFG_FS:     fs_r     <= cfg_wdata[FS_W-1:0];
        CFG_INVERT: inv_r    <= cfg_wdata[0];
        CFG_CAP:    cap_ah_r <= cfg_wdata[CAPAH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_current_ma     = ocur_r;
  assign out_average_ma     = oavg_r;
  assign out_soc_hundredths = osoc_r;
  assign out_charging       = ochg_r;
  assign out_discharging    = odis_r;
  assign out_charged_mas    = oct_r;
  assign out_discharged_mas = odt_r;

endmodule

// ----- rtl/bccc_arith.sv -----
`timescale 1ns / 1ps

// Bit-serial shift-and-add multiplier / restoring divider.
// MUL: result = a * b, one multiplier bit (LSB first) per clock.
// DIV: result = a / b, a pre-aligned so its cnt significant bits sit at the
//      top of the word; one quotient bit per clock.
module bccc_arith (
  input  logic              clk,
  input  logic              rst_n,
  input  bccc_pkg::ar_req_t req,
  output bccc_pkg::ar_rsp_t rsp
);
  import bccc_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             op_r, op_nxt;
  logic [AR_CW-1:0] cnt_r, cnt_nxt;
  logic [AR_W-1:0]  x_r, x_nxt;
  logic [AR_W-1:0]  y_r, y_nxt;
  logic [AR_BW-1:0] b_r, b_nxt;

  logic [AR_BW:0]   rem_sh;
  logic [AR_BW+1:0] rem_diff;
  logic             rem_ge;

  // Divider trial subtract: shift next dividend bit into the remainder
  assign rem_sh   = {y_r[AR_BW-1:0], x_r[AR_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, b_r};
  assign rem_ge   = ~rem_diff[AR_BW+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = req.cnt;
      x_nxt    = req.a;
      y_nxt    = '0;
      b_nxt    = req.b;
    end else if (busy_r) begin
      if (op_r == AR_OP_DIV) begin
        // x: dividend out at top, quotient in at bottom; y: remainder
        x_nxt = {x_r[AR_W-2:0], rem_ge};
        y_nxt = {{(AR_W-AR_BW){1'b0}},
                 (rem_ge ? rem_diff[AR_BW-1:0] : rem_sh[AR_BW-1:0])};
      end else begin
        // x: shifted multiplicand; y: accumulator; b: multiplier
        if (b_r[0]) begin
          y_nxt = y_r + x_r;
        end
        x_nxt = {x_r[AR_W-2:0], 1'b0};
        b_nxt = {1'b0, b_r[AR_BW-1:1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == AR_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == AR_OP_DIV) ? x_r : y_r;

endmodule
